### design/ctt_pkg.sv
// Shared types and constants for the calendar timer table.
`timescale 1ns / 1ps
`default_nettype none
package ctt_pkg;

    localparam int TIME_W      = 45;
    localparam int HANDLE_IN_W = 16;
    localparam int EVENT_IN_W  = 16;

    localparam logic [13:0] YEAR_MIN  = 14'd1901;
    localparam logic [13:0] YEAR_MAX  = 14'd2099;
    localparam logic [1:0]  LEAP_MASK = 2'h3;
    localparam logic [4:0]  FEB_LEAP  = 5'd29;
    localparam logic [3:0]  FEBRUARY  = 4'd2;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_STOP = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_HANDLE = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_FIRED  = 2'd2
    } t_kind;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic claim_en;
        logic stop_en;
        logic due_en;
        logic fire_en;
    } t_cell_cmd;

    // days in a month, zero for a month out of range
    function automatic logic [4:0] month_days(input logic [3:0] mo);
        logic [4:0] d;
        d = 5'd0;
        if (mo >= 4'd1 && mo <= 4'd12) begin
            d = MONTH_LEN[4'(mo - 4'd1)];
        end
        return d;
    endfunction

endpackage
`default_nettype wire

### design/ctt_time_pack.sv
// Calendar time check and packing into a 45-bit ordered word.
`timescale 1ns / 1ps
`default_nettype none
module ctt_time_pack
    import ctt_pkg::*;
(
    input  wire logic [13:0]       i_year,
    input  wire logic [6:0]        i_month,
    input  wire logic [6:0]        i_day,
    input  wire logic [6:0]        i_hour,
    input  wire logic [6:0]        i_minute,
    input  wire logic [6:0]        i_second,
    input  wire logic [6:0]        i_centisecond,
    output logic [TIME_W-1:0]      o_packed,
    output logic                   o_valid
);

    logic [4:0] w_dim;
    logic       w_month_ok;

    assign w_month_ok = (i_month >= 7'd1) && (i_month <= 7'd12);

    always_comb begin
        w_dim = month_days(i_month[3:0]);
        if (i_month[3:0] == FEBRUARY && (i_year[1:0] & LEAP_MASK) == 2'b00) begin
            w_dim = FEB_LEAP;
        end
    end

    assign o_valid = (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX) && w_month_ok &&
                     (i_day >= 7'd1) && (i_day <= {2'b00, w_dim}) &&
                     (i_hour <= 7'd23) && (i_minute <= 7'd59) &&
                     (i_second <= 7'd59) && (i_centisecond <= 7'd99);

    assign o_packed = {i_year[11:0], i_month[3:0], i_day[4:0], i_hour[4:0],
                       i_minute[5:0], i_second[5:0], i_centisecond};

endmodule
`default_nettype wire

### design/ctt_cell.sv
// One timer slot of the chain: storage, claim, stop and fire tokens.
`timescale 1ns / 1ps
`default_nettype none
module ctt_cell
    import ctt_pkg::*;
#(
    parameter int HANDLE_WIDTH = 16,
    parameter int EVENT_WIDTH  = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cell_cmd               i_cmd,
    input  wire logic [TIME_W-1:0]       i_time,
    input  wire logic [EVENT_WIDTH-1:0]  i_event,
    input  wire logic [HANDLE_WIDTH-1:0] i_new_handle,
    input  wire logic [HANDLE_IN_W-1:0]  i_stop_handle,
    input  wire logic                    i_claim,
    output logic                         o_claim,
    input  wire logic                    i_found,
    output logic                         o_found,
    input  wire logic                    i_fire,
    output logic                         o_fire,
    output logic                         o_due_left,
    output logic [EVENT_WIDTH-1:0]       o_event
);

    localparam int HCW = (HANDLE_WIDTH > HANDLE_IN_W) ? HANDLE_WIDTH : HANDLE_IN_W;

    logic                    r_busy;
    logic                    r_due;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [EVENT_WIDTH-1:0]  r_event;
    logic [TIME_W-1:0]       r_expiry;

    logic w_take;
    logic w_match;
    logic w_stop;
    logic w_first_due;
    logic w_fire_here;

    // lowest free slot: token enters at index 0, passes busy cells
    assign w_take  = i_cmd.claim_en && i_claim && !r_busy;
    assign o_claim = i_claim && r_busy;

    // highest matching slot: token enters at the top index
    assign w_match = r_busy && (HCW'(r_handle) == HCW'(i_stop_handle));
    assign w_stop  = i_cmd.stop_en && w_match && !i_found;
    assign o_found = i_found || w_match;

    // lowest due slot fires; due-left and event do not depend on the enable
    assign w_first_due = i_fire && r_due;
    assign w_fire_here = i_cmd.fire_en && w_first_due;
    assign o_fire      = i_fire && !r_due;
    assign o_due_left  = r_due && !i_fire;
    assign o_event     = w_first_due ? r_event : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_due  <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
            end else if (w_stop || w_fire_here) begin
                r_busy <= 1'b0;
            end
            if (i_cmd.due_en) begin
                r_due <= r_busy && (r_expiry <= i_time);
            end else if (w_fire_here) begin
                r_due <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_handle <= i_new_handle;
            r_event  <= i_event;
            r_expiry <= i_time;
        end
    end

endmodule
`default_nettype wire

### design/calendar_timer_table_top.sv
// Calendar timer table: request decode, sequencer and the chain of timer cells.
// A request is taken in S_IDLE and carried out in S_EXEC. A set gives its result
// from S_EXEC, later while the output is stalled; a stop gives none; a tick marks the
// due slots in S_EXEC and then gives its fired events from S_FIRE, one per cycle while
// taken. A new request is taken only back in S_IDLE. Synchronous reset clears all
// slots, time and counter.
`timescale 1ns / 1ps
`default_nettype none
module calendar_timer_table_top
    import ctt_pkg::*;
#(
    parameter int NUM_TIMERS   = 32,
    parameter int HANDLE_WIDTH = 16,
    parameter int EVENT_WIDTH  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [13:0] i_year,
    input  wire logic [6:0]  i_month,
    input  wire logic [6:0]  i_day,
    input  wire logic [6:0]  i_hour,
    input  wire logic [6:0]  i_minute,
    input  wire logic [6:0]  i_second,
    input  wire logic [6:0]  i_centisecond,
    input  wire logic [15:0] i_event_id,
    input  wire logic [15:0] i_handle,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_timer_handle,
    output logic [15:0]      o_fired_event,
    output logic             o_last
);

    localparam int EVW = (EVENT_WIDTH < EVENT_IN_W) ? EVENT_WIDTH : EVENT_IN_W;
    localparam int HOW = (HANDLE_WIDTH < 16) ? HANDLE_WIDTH : 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIRE
    } t_state;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    logic [TIME_W-1:0]       r_time;
    logic                    r_tvalid;
    logic [EVENT_WIDTH-1:0]  r_ev;
    logic [HANDLE_IN_W-1:0]  r_hnd;
    logic [TIME_W-1:0]       r_cur, n_cur;
    logic [HANDLE_WIDTH-1:0] r_cnt, n_cnt;

    logic                    r_o_valid, n_o_valid;
    t_kind                   r_o_kind, n_o_kind;
    logic [15:0]             r_o_handle, n_o_handle;
    logic [15:0]             r_o_event, n_o_event;
    logic                    r_o_last, n_o_last;

    logic [TIME_W-1:0]       w_packed;
    logic                    w_pvalid;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic [HANDLE_WIDTH-1:0] w_inc;
    logic [HANDLE_WIDTH-1:0] w_next_handle;
    t_cell_cmd               w_ccmd;

    logic [NUM_TIMERS:0]     w_claim;
    logic [NUM_TIMERS:0]     w_found;
    logic [NUM_TIMERS:0]     w_fire;
    logic [NUM_TIMERS-1:0]   w_due_left;
    logic [EVENT_WIDTH-1:0]  w_cell_ev [NUM_TIMERS];
    logic [EVENT_WIDTH-1:0]  w_fired_ev;

    ctt_time_pack u_pack (
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_centisecond (i_centisecond),
        .o_packed      (w_packed),
        .o_valid       (w_pvalid)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    assign w_inc         = r_cnt + HANDLE_WIDTH'(1);
    assign w_next_handle = (w_inc == '0) ? HANDLE_WIDTH'(1) : w_inc;

    assign w_claim[0]          = 1'b1;
    assign w_found[NUM_TIMERS] = 1'b0;
    assign w_fire[0]           = 1'b1;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        ctt_cell #(
            .HANDLE_WIDTH (HANDLE_WIDTH),
            .EVENT_WIDTH  (EVENT_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_ccmd),
            .i_time        (r_time),
            .i_event       (r_ev),
            .i_new_handle  (w_next_handle),
            .i_stop_handle (r_hnd),
            .i_claim       (w_claim[g]),
            .o_claim       (w_claim[g+1]),
            .i_found       (w_found[g+1]),
            .o_found       (w_found[g]),
            .i_fire        (w_fire[g]),
            .o_fire        (w_fire[g+1]),
            .o_due_left    (w_due_left[g]),
            .o_event       (w_cell_ev[g])
        );
    end

    // at most one cell drives a non-zero event
    always_comb begin
        w_fired_ev = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_fired_ev = w_fired_ev | w_cell_ev[i];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_kind   = r_o_kind;
        n_o_handle = r_o_handle;
        n_o_event  = r_o_event;
        n_o_last   = r_o_last;
        w_ccmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_SET: begin
                        if (w_out_free) begin
                            n_state    = S_IDLE;
                            n_o_valid  = 1'b1;
                            n_o_last   = 1'b1;
                            n_o_handle = '0;
                            n_o_event  = '0;
                            priority if (!r_tvalid || r_ev == '0) begin
                                n_o_kind = KIND_ERROR;
                            end else if (r_time <= r_cur) begin
                                n_o_kind  = KIND_FIRED;
                                n_o_event = 16'(r_ev[EVW-1:0]);
                            end else if (w_claim[NUM_TIMERS]) begin
                                n_o_kind = KIND_ERROR;
                            end else begin
                                n_o_kind        = KIND_HANDLE;
                                n_o_handle      = 16'(w_next_handle[HOW-1:0]);
                                n_cnt           = w_next_handle;
                                w_ccmd.claim_en = 1'b1;
                            end
                        end
                    end
                    CMD_STOP: begin
                        n_state        = S_IDLE;
                        w_ccmd.stop_en = (r_hnd != '0);
                    end
                    CMD_TICK: begin
                        if (r_tvalid) begin
                            n_cur         = r_time;
                            w_ccmd.due_en = 1'b1;
                            n_state       = S_FIRE;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FIRE: begin
                if (w_fire[NUM_TIMERS]) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_ccmd.fire_en = 1'b1;
                    n_o_valid      = 1'b1;
                    n_o_kind       = KIND_FIRED;
                    n_o_handle     = '0;
                    n_o_event      = 16'(w_fired_ev[EVW-1:0]);
                    n_o_last       = !(|w_due_left);
                    if (!(|w_due_left)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_o_kind   <= n_o_kind;
        r_o_handle <= n_o_handle;
        r_o_event  <= n_o_event;
        r_o_last   <= n_o_last;
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_time   <= w_packed;
            r_tvalid <= w_pvalid;
            r_ev     <= EVENT_WIDTH'(i_event_id[EVW-1:0]);
            r_hnd    <= i_handle;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_timer_handle = r_o_handle;
    assign o_fired_event  = r_o_event;
    assign o_last         = r_o_last;

endmodule
`default_nettype wire

### design/ctt_checker.sv
// Port-level assertions for the calendar timer table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ctt_checker
    import ctt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_cmd,
    input wire logic [13:0] i_year,
    input wire logic [6:0]  i_month,
    input wire logic [6:0]  i_day,
    input wire logic [6:0]  i_hour,
    input wire logic [6:0]  i_minute,
    input wire logic [6:0]  i_second,
    input wire logic [6:0]  i_centisecond,
    input wire logic [15:0] i_event_id,
    input wire logic [15:0] i_handle,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_kind,
    input wire logic [15:0] o_timer_handle,
    input wire logic [15:0] o_fired_event,
    input wire logic        o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_timer_handle)
            && $stable(o_fired_event) && $stable(o_last))
        else $error("result changed while stalled");

    // an issued handle is never zero and closes its request
    a_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_HANDLE |-> o_timer_handle != 16'd0
            && o_fired_event == 16'd0 && o_last)
        else $error("bad handle result");

    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR |-> o_timer_handle == 16'd0
            && o_fired_event == 16'd0 && o_last)
        else $error("bad error result");

    // a taken request keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken back to back");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind calendar_timer_table_top ctt_checker u_ctt_checker (.*);
`default_nettype wire

### tb/sv/calendar_timer_table_top_tb.sv
// Self-checking testbench for the calendar timer table: directed, random and full table tests.
`timescale 1ns / 1ps
`default_nettype none
module calendar_timer_table_top_tb;
    import ctt_pkg::*;

    localparam int NUM_SLOTS    = 32;
    localparam int DAY_CS       = 8640000;
    localparam int RANDOM_ITEMS = 250;
    localparam int MAX_PRINTS   = 30;
    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        t_cmd        cmd;
        logic [13:0] year;
        logic [6:0]  month, day, hour, minute, second, centi;
        logic [15:0] event_id;
        logic [15:0] handle;
    } t_request;

    typedef struct {
        t_kind       kind;
        logic [15:0] timer_handle;
        logic [15:0] fired_event;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n, i_valid, i_ready;
    logic        o_ready, o_valid, o_last;
    logic [1:0]  i_cmd, o_kind;
    logic [13:0] i_year;
    logic [6:0]  i_month, i_day, i_hour, i_minute, i_second, i_centisecond;
    logic [15:0] i_event_id, i_handle, o_timer_handle, o_fired_event;

    // timer table as the block should hold it
    logic        tmr_busy   [NUM_SLOTS];
    logic [15:0] tmr_handle [NUM_SLOTS];
    logic [15:0] tmr_event  [NUM_SLOTS];
    logic [44:0] tmr_expiry [NUM_SLOTS];
    logic [44:0] now_time;
    logic [15:0] handle_count;

    t_result due_results[$];

    // calendar that drives the well-formed random traffic
    int cal_year = 2000, cal_month = 1, cal_day = 1, clock_cs = 0;

    int  n_requests, n_random, n_checked, n_handles, n_err_results, n_fired, n_mismatch;
    int  burst_left;
    bit  steady = 1'b0;
    logic [7:0] stall_mask = 8'hFF;
    logic [5:0] rx_phase = 6'd0;

    calendar_timer_table_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_centisecond (i_centisecond),
        .i_event_id    (i_event_id),
        .i_handle      (i_handle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_timer_handle(o_timer_handle),
        .o_fired_event (o_fired_event),
        .o_last        (o_last)
    );

    always #10 i_clk = ~i_clk;

    function automatic int month_length(input int yr, input int mo);
        if (mo < 1 || mo > 12) return 0;
        if (mo == 2 && yr % 4 == 0) return 29;
        return DAYS_IN_MONTH[mo - 1];
    endfunction

    // checks the date and time and packs it so that numeric order is calendar order
    function automatic bit encode_time(input t_request r, output logic [44:0] stamp);
        int dim;
        dim = month_length(r.year, r.month);
        stamp = {r.year[11:0], r.month[3:0], r.day[4:0], r.hour[4:0],
                 r.minute[5:0], r.second[5:0], r.centi};
        if (r.year < 1901 || r.year > 2099 || dim == 0) return 0;
        if (r.day < 1 || r.day > dim) return 0;
        if (r.hour > 23 || r.minute > 59 || r.second > 59 || r.centi > 99) return 0;
        return 1;
    endfunction

    function automatic t_request make_request(input t_cmd c, input int yr, input int mo,
                                              input int dy, input int hr, input int mi,
                                              input int se, input int cs, input int ev,
                                              input int hd);
        t_request r;
        r.cmd      = c;
        r.year     = yr[13:0];
        r.month    = mo[6:0];
        r.day      = dy[6:0];
        r.hour     = hr[6:0];
        r.minute   = mi[6:0];
        r.second   = se[6:0];
        r.centi    = cs[6:0];
        r.event_id = ev[15:0];
        r.handle   = hd[15:0];
        return r;
    endfunction

    // request timed on the random calendar's current day
    function automatic t_request clock_request(input t_cmd c, input int cs, input int ev);
        return make_request(c, cal_year, cal_month, cal_day, cs / 360000, (cs / 6000) % 60,
                            (cs / 100) % 60, cs % 100, ev, 0);
    endfunction

    function automatic void queue_result(input t_kind k, input logic [15:0] h,
                                         input logic [15:0] ev, input logic lst);
        t_result res;
        res.kind         = k;
        res.timer_handle = h;
        res.fired_event  = ev;
        res.last         = lst;
        due_results.push_back(res);
        case (k)
            KIND_HANDLE: n_handles++;
            KIND_ERROR:  n_err_results++;
            default:     n_fired++;
        endcase
    endfunction

    // updates the table for one accepted request and queues the results it causes;
    // effective is low when the block should leave everything as it was
    task automatic apply_request(input t_request r, output bit effective);
        logic [44:0] stamp;
        int          free_idx, fired;
        effective = 1'b1;
        case (r.cmd)
            CMD_SET: begin
                if (!encode_time(r, stamp) || r.event_id == 16'd0) begin
                    queue_result(KIND_ERROR, 16'd0, 16'd0, 1'b1);
                end else if (stamp <= now_time) begin
                    queue_result(KIND_FIRED, 16'd0, r.event_id, 1'b1);
                end else begin
                    free_idx = -1;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!tmr_busy[i]) begin
                            free_idx = i;
                            break;
                        end
                    end
                    if (free_idx < 0) begin
                        queue_result(KIND_ERROR, 16'd0, 16'd0, 1'b1);
                    end else begin
                        handle_count = handle_count + 16'd1;
                        if (handle_count == 16'd0) handle_count = 16'd1;
                        tmr_busy[free_idx]   = 1'b1;
                        tmr_handle[free_idx] = handle_count;
                        tmr_event[free_idx]  = r.event_id;
                        tmr_expiry[free_idx] = stamp;
                        queue_result(KIND_HANDLE, handle_count, 16'd0, 1'b1);
                    end
                end
            end
            CMD_STOP: begin
                effective = 1'b0;
                if (r.handle != 16'd0) begin
                    // highest index wins when a reused handle appears twice
                    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                        if (tmr_busy[i] && tmr_handle[i] == r.handle) begin
                            tmr_busy[i] = 1'b0;
                            effective   = 1'b1;
                            break;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (!encode_time(r, stamp)) begin
                    effective = 1'b0;
                end else begin
                    now_time = stamp;
                    fired    = 0;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (tmr_busy[i] && tmr_expiry[i] <= now_time) begin
                            queue_result(KIND_FIRED, 16'd0, tmr_event[i], 1'b0);
                            tmr_busy[i] = 1'b0;
                            fired++;
                        end
                    end
                    if (fired > 0) due_results[$].last = 1'b1;
                end
            end
            default: effective = 1'b0;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // sender: bursts of back-to-back requests separated by random gaps
    task automatic send_request(input t_request r, output bit effective);
        int gap;
        if (burst_left == 0 && !steady) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_cmd         = r.cmd;
        i_year        = r.year;
        i_month       = r.month;
        i_day         = r.day;
        i_hour        = r.hour;
        i_minute      = r.minute;
        i_second      = r.second;
        i_centisecond = r.centi;
        i_event_id    = r.event_id;
        i_handle      = r.handle;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        apply_request(r, effective);
        if (burst_left > 0) burst_left--;
        n_requests++;
    endtask

    // receiver: stall mask reloaded whenever the phase counter wraps, sometimes all ready
    always @(negedge i_clk) begin
        if (steady) begin
            i_ready <= 1'b1;
        end else begin
            if (rx_phase == 6'd0) begin
                stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                if (stall_mask == 8'h00) stall_mask = 8'h01;
            end
            i_ready  <= stall_mask[rx_phase[2:0]];
            rx_phase <= rx_phase + 6'd1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_checked++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d handle %0h event %0h",
                                          o_kind, o_timer_handle, o_fired_event));
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
                if (o_timer_handle !== want.timer_handle)
                    report_mismatch($sformatf("handle %0h, want %0h",
                                              o_timer_handle, want.timer_handle));
                if (o_fired_event !== want.fired_event)
                    report_mismatch($sformatf("event %0h, want %0h",
                                              o_fired_event, want.fired_event));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    // field limits of a set, leap February, a zero event id
    task automatic test_set_checks();
        bit eff;
        send_request(make_request(CMD_SET, 1901, 1, 1, 0, 0, 0, 0, 1, 0), eff);
        send_request(make_request(CMD_SET, 2099, 12, 31, 23, 59, 59, 99, 'hFFFF, 0), eff);
        send_request(make_request(CMD_SET, 1900, 6, 15, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2100, 6, 15, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 0, 15, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 13, 15, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 3, 0, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2023, 2, 29, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 2, 29, 12, 0, 0, 0, 'h8000, 0), eff);
        send_request(make_request(CMD_SET, 2024, 4, 31, 12, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 5, 1, 24, 0, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 5, 1, 12, 60, 0, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 5, 1, 12, 0, 60, 0, 5, 0), eff);
        send_request(make_request(CMD_SET, 2024, 5, 1, 12, 0, 0, 100, 5, 0), eff);
        send_request(make_request(CMD_SET, 9999, 99, 99, 99, 99, 99, 99, 'hFFFF, 'hFFFF), eff);
        send_request(make_request(CMD_SET, 2024, 5, 1, 12, 0, 0, 0, 0, 0), eff);
    endtask

    task automatic test_stop_cases();
        bit eff;
        send_request(make_request(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0), eff);
        send_request(make_request(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF), eff);
        send_request(make_request(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 2), eff);
        send_request(make_request(CMD_NONE, 2024, 5, 1, 12, 0, 0, 0, 9, 1), eff);
    endtask

    // bad tick, expiry equal to the tick, immediate fire, backwards tick
    task automatic test_tick_cases();
        bit eff;
        send_request(make_request(CMD_TICK, 2024, 2, 30, 0, 0, 0, 0, 0, 0), eff);
        send_request(make_request(CMD_TICK, 1901, 1, 1, 0, 0, 0, 0, 0, 0), eff);
        send_request(make_request(CMD_SET, 1901, 1, 1, 0, 0, 0, 0, 7, 0), eff);
        send_request(make_request(CMD_TICK, 2024, 2, 29, 12, 0, 0, 0, 0, 0), eff);
        send_request(make_request(CMD_TICK, cal_year, cal_month, cal_day, 0, 0, 0, 0, 0, 0), eff);
    endtask

    task automatic test_random_traffic();
        t_request r;
        bit       eff;
        int       counted, seg_left, mode, pick, set_cut, stop_cut, cs, busy_cnt, sel;
        counted  = 0;
        seg_left = 0;
        mode     = 0;
        while (counted < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                // mixed, filling the table, or draining it
                mode     = $urandom_range(0, 2);
                seg_left = 40;
            end
            seg_left--;
            set_cut  = (mode == 1) ? 88 : (mode == 2) ? 45 : 55;
            stop_cut = (mode == 1) ? 93 : (mode == 2) ? 70 : 75;
            pick     = $urandom_range(0, 99);
            if (pick < 12) begin
                r = make_request(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 9999),
                                 $urandom_range(0, 99), $urandom_range(0, 99),
                                 $urandom_range(0, 99), $urandom_range(0, 99),
                                 $urandom_range(0, 99), $urandom_range(0, 99),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (pick < 15) begin
                r = clock_request(CMD_SET, clock_cs + 100, 0);
            end else if (pick < set_cut) begin
                cs = ($urandom_range(0, 15) == 0) ? clock_cs
                                                  : clock_cs + $urandom_range(0, 400000) - 60000;
                if (cs < 0) cs = 0;
                if (cs >= DAY_CS) cs = DAY_CS - 1;
                r = clock_request(CMD_SET, cs, $urandom_range(1, 65535));
            end else if (pick < stop_cut) begin
                r = make_request(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0,
                                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65535));
                busy_cnt = 0;
                foreach (tmr_busy[i]) if (tmr_busy[i]) busy_cnt++;
                if (busy_cnt > 0 && $urandom_range(0, 4) != 0) begin
                    sel = $urandom_range(0, busy_cnt - 1);
                    foreach (tmr_busy[i]) begin
                        if (tmr_busy[i]) begin
                            if (sel == 0) r.handle = tmr_handle[i];
                            sel--;
                        end
                    end
                end
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    cal_year  = $urandom_range(1901, 2099);
                    cal_month = $urandom_range(1, 12);
                    cal_day   = $urandom_range(1, month_length(cal_year, cal_month));
                    clock_cs  = $urandom_range(0, DAY_CS - 1);
                end else begin
                    clock_cs += (mode == 2) ? $urandom_range(0, 600000)
                                            : $urandom_range(0, 150000);
                    while (clock_cs >= DAY_CS) begin
                        clock_cs -= DAY_CS;
                        cal_day++;
                        if (cal_day > month_length(cal_year, cal_month)) begin
                            cal_day = 1;
                            cal_month++;
                            if (cal_month > 12) begin
                                cal_month = 1;
                                cal_year  = (cal_year == 2099) ? 1901 : cal_year + 1;
                            end
                        end
                    end
                end
                r = clock_request(CMD_TICK, clock_cs, 0);
            end
            send_request(r, eff);
            n_random++;
            counted++;
        end
    endtask

    // fills every slot, asks for one more, frees and refills a middle slot,
    // then one tick fires the whole table in slot order under receiver stalls
    task automatic test_full_table();
        bit eff;
        steady = 1'b1;
        send_request(make_request(CMD_TICK, 2099, 12, 31, 23, 59, 59, 98, 0, 0), eff);
        for (int i = 0; i <= NUM_SLOTS; i++) begin
            send_request(make_request(CMD_SET, 2099, 12, 31, 23, 59, 59, 99, 'h0100 + i, 0),
                         eff);
        end
        send_request(make_request(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, tmr_handle[5]), eff);
        send_request(make_request(CMD_SET, 2099, 12, 31, 23, 59, 59, 99, 'h0BAD, 0), eff);
        steady = 1'b0;
        send_request(make_request(CMD_TICK, 2099, 12, 31, 23, 59, 59, 99, 0, 0), eff);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = CMD_NONE;
        i_year = '0;
        i_month = '0;
        i_day = '0;
        i_hour = '0;
        i_minute = '0;
        i_second = '0;
        i_centisecond = '0;
        i_event_id = '0;
        i_handle = '0;
        foreach (tmr_busy[i]) tmr_busy[i] = 1'b0;
        now_time     = '0;
        handle_count = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_set_checks();
        test_stop_cases();
        test_tick_cases();
        test_random_traffic();
        test_full_table();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests (%0d random), checked %0d results.",
                 n_requests, n_random, n_checked);
        $display("Expected %0d handles, %0d errors and %0d fired events; full table fired.",
                 n_handles, n_err_results, n_fired);
        if (n_mismatch == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
design/ctt_pkg.sv
design/ctt_time_pack.sv
design/ctt_cell.sv
design/calendar_timer_table_top.sv
design/ctt_checker.sv
tb/sv/calendar_timer_table_top_tb.sv
